### hw/rtl/ekd_pkg.sv
// Shared types and constants for the exact-k distinct subarray counter.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ekd_pkg;

    localparam int VALUE_W         = 10;
    localparam int K_W             = 11;
    localparam int COUNT_W         = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 24;

    localparam int MAX_LEN_DEF     = 1024;
    localparam int VALUE_RANGE_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    // register index, decoded from the word address paddr[CFG_ADDR_W-1:2]
    localparam logic [CFG_ADDR_W-3:0] REG_K_DISTINCT = '0;
    localparam logic [K_W-1:0]        K_RESET        = K_W'(1);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               reject;
    } ekd_item_t;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } ekd_status_t;

endpackage

`default_nettype wire

### hw/rtl/exact_k_distinct_subarray_counter.sv
// Top level: configuration register, front end, item queue and window engine.
// Depends on ekd_pkg, ekd_front, ekd_queue and ekd_back.
//
//  channel   direction  transfer when              contents
//  s_axis    in         s_axis_tvalid & tready     tdata[9:0] value, tlast last
//  m_axis    out        m_axis_tvalid & tready     tdata[19:0] good_count, tlast done_res,
//                                                  tuser[0] rejected
//  apb       in         psel & penable & pwrite    0x0 k_distinct[10:0], reset value 1
//
// An accepted value runs the add steps in the window engine plus a shrink step for every element
// that drops out of a window (both windows step together); an ignored item goes straight to output.
// After a transfer with tlast, the engine walks both windows empty, one step per element
// left in the longer window, and then clears the sequence state. The history and frequency
// memories (one read-modify-write per step) shape these steps.
// After reset the frequency tables are zeroed, one entry a cycle across all VALUE_RANGE entries;
// the input side fills the 4-entry queue meanwhile and then stalls.
// A result waiting in the output register only holds the engine back; the queue takes input until full.
`timescale 1ns / 1ps
`default_nettype none

module exact_k_distinct_subarray_counter #(
    parameter int MAX_LEN     = ekd_pkg::MAX_LEN_DEF,
    parameter int VALUE_RANGE = ekd_pkg::VALUE_RANGE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [ekd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] value
    input  wire logic                            s_axis_tlast,  // last
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [ekd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [19:0] good_count
    output logic                                 m_axis_tlast,  // done_res
    output logic                                 m_axis_tuser,  // [0] rejected
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ekd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [ekd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ekd_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import ekd_pkg::*;

    logic [K_W-1:0] k_distinct_reg;
    logic [K_W-1:0] k_distinct_next;
    logic           cfg_write;

    ekd_item_t      push_item;
    ekd_item_t      head_item;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    ekd_status_t    status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[CFG_ADDR_W-1:2] == REG_K_DISTINCT);
    assign prdata    = (paddr[CFG_ADDR_W-1:2] == REG_K_DISTINCT)
                       ? CFG_DATA_W'(k_distinct_reg) : '0;

    always_comb begin
        k_distinct_next = k_distinct_reg;
        if (cfg_write) begin
            k_distinct_next = pwdata[K_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_distinct_reg <= K_RESET;
        end else begin
            k_distinct_reg <= k_distinct_next;
        end
    end

    ekd_front #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_RANGE (VALUE_RANGE)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (push),
        .q_item        (push_item)
    );

    ekd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head_item (head_item)
    );

    ekd_back #(
        .MAX_LEN     (MAX_LEN),
        .VALUE_RANGE (VALUE_RANGE)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .k_distinct    (k_distinct_reg),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .status        (status)
    );

    // no result may appear while the tables are still being zeroed
    a_no_result_in_init : assert property (@(posedge aclk) disable iff (!aresetn)
        status.init_busy |-> !m_axis_tvalid)
        else $error("result presented during table clearing pass");

    // an idle engine with a queued item must take it in the next cycle
    a_idle_takes_item : assert property (@(posedge aclk) disable iff (!aresetn)
        (status.idle && q_valid) |=> !status.idle)
        else $error("engine idle while the queue holds an item");

    // a queued item is only popped by an idle engine
    a_pop_when_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (status.idle && q_valid))
        else $error("queue popped outside the idle state");

endmodule

`default_nettype wire

### hw/rtl/ekd_front.sv
// Front end: accepts input transfers, tracks sequence length and marks items to ignore.
// Depends on ekd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ekd_front #(
    parameter int MAX_LEN     = ekd_pkg::MAX_LEN_DEF,
    parameter int VALUE_RANGE = ekd_pkg::VALUE_RANGE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [ekd_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [9:0] value
    input  wire logic                           s_axis_tlast,  // last
    input  wire logic                           q_full,
    output logic                                q_push,
    output ekd_pkg::ekd_item_t                  q_item
);
    import ekd_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);

    logic [POS_W-1:0]   len_reg;
    logic [POS_W-1:0]   len_next;
    logic [VALUE_W-1:0] value;
    logic               reject;

    assign value         = s_axis_tdata[VALUE_W-1:0];
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    assign reject = (len_reg >= POS_W'(MAX_LEN)) || (32'(value) >= 32'(VALUE_RANGE));

    always_comb begin
        q_item.value  = value;
        q_item.last   = s_axis_tlast;
        q_item.reject = reject;
    end

    always_comb begin
        len_next = len_reg;
        if (q_push) begin
            if (s_axis_tlast) begin
                len_next = '0;
            end else if (!reject) begin
                len_next = len_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ekd_queue.sv
// Short item queue between the front end and the window engine.
// Depends on ekd_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module ekd_queue #(
    parameter int DEPTH = ekd_pkg::QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  ekd_pkg::ekd_item_t      push_item,
    input  wire logic               pop,
    output logic                    full,
    output logic                    valid,
    output ekd_pkg::ekd_item_t      head_item
);
    import ekd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ekd_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign valid     = (fill_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ekd_back.sv
// Window engine: history and frequency memories, the two sliding windows and the result register.
// Depends on ekd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ekd_back #(
    parameter int MAX_LEN     = ekd_pkg::MAX_LEN_DEF,
    parameter int VALUE_RANGE = ekd_pkg::VALUE_RANGE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [ekd_pkg::K_W-1:0]         k_distinct,
    input  wire logic                            q_valid,
    input  ekd_pkg::ekd_item_t                   q_item,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [ekd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [19:0] good_count
    output logic                                 m_axis_tlast,  // done_res
    output logic                                 m_axis_tuser,  // [0] rejected
    output ekd_pkg::ekd_status_t                 status
);
    import ekd_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int HA_W  = $clog2(MAX_LEN);
    localparam int FQ_AW = $clog2(VALUE_RANGE);
    localparam int CMP_W = (POS_W > K_W) ? POS_W : K_W;
    localparam int SUM_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_ADD_RD = 4'd2;
    localparam logic [3:0] ST_ADD_WR = 4'd3;
    localparam logic [3:0] ST_CHK    = 4'd4;
    localparam logic [3:0] ST_HIST   = 4'd5;
    localparam logic [3:0] ST_FREQ   = 4'd6;
    localparam logic [3:0] ST_DEC    = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [VALUE_W-1:0] hist_mem [MAX_LEN];
    logic [POS_W-1:0]   fa_mem   [VALUE_RANGE];
    logic [POS_W-1:0]   fb_mem   [VALUE_RANGE];

    logic [3:0]         state_reg, state_next;
    ekd_item_t          cur_reg, cur_next;
    logic [POS_W-1:0]   wp_reg, wp_next;
    logic [POS_W-1:0]   left_a_reg, left_a_next;
    logic [POS_W-1:0]   left_b_reg, left_b_next;
    logic [POS_W-1:0]   dist_a_reg, dist_a_next;
    logic [POS_W-1:0]   dist_b_reg, dist_b_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               clearing_reg, clearing_next;
    logic               act_a_reg, act_a_next;
    logic               act_b_reg, act_b_next;
    logic [FQ_AW-1:0]   init_idx_reg, init_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_last_reg, m_last_next;
    logic               m_rej_reg, m_rej_next;

    logic [VALUE_W-1:0] ha_reg, hb_reg;
    logic [POS_W-1:0]   fa_rd_reg, fb_rd_reg;

    logic               hist_we;
    logic               fa_we, fb_we;
    logic [FQ_AW-1:0]   fa_wa, fb_wa, fa_ra, fb_ra;
    logic [POS_W-1:0]   fa_wd, fb_wd;

    logic [CMP_W-1:0]   lim_hi, lim_lo;
    logic               cond_a, cond_b;
    logic [POS_W-1:0]   gap;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] total_sat;
    logic               out_free;

    assign lim_hi = CMP_W'(k_distinct);
    assign lim_lo = (k_distinct == '0) ? '0 : CMP_W'(k_distinct - K_W'(1));

    // shrink while too many distinct values; after the last item, walk the windows empty
    always_comb begin
        if (clearing_reg) begin
            cond_a = left_a_reg < wp_reg;
            cond_b = left_b_reg < wp_reg;
        end else begin
            cond_a = (CMP_W'(dist_a_reg) > lim_hi) && (left_a_reg <= wp_reg);
            cond_b = (CMP_W'(dist_b_reg) > lim_lo) && (left_b_reg <= wp_reg);
        end
    end

    assign gap       = (left_b_reg >= left_a_reg) ? left_b_reg - left_a_reg : '0;
    assign sum       = SUM_W'(total_reg) + SUM_W'(gap);
    assign total_sat = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
    assign out_free  = !m_valid_reg || m_axis_tready;

    assign fa_ra = (state_reg == ST_FREQ) ? FQ_AW'(ha_reg) : FQ_AW'(cur_reg.value);
    assign fb_ra = (state_reg == ST_FREQ) ? FQ_AW'(hb_reg) : FQ_AW'(cur_reg.value);

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        wp_next       = wp_reg;
        left_a_next   = left_a_reg;
        left_b_next   = left_b_reg;
        dist_a_next   = dist_a_reg;
        dist_b_next   = dist_b_reg;
        total_next    = total_reg;
        clearing_next = clearing_reg;
        act_a_next    = act_a_reg;
        act_b_next    = act_b_reg;
        init_idx_next = init_idx_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        m_rej_next    = m_rej_reg;
        q_pop         = 1'b0;
        hist_we       = 1'b0;
        fa_we         = 1'b0;
        fb_we         = 1'b0;
        fa_wa         = FQ_AW'(cur_reg.value);
        fb_wa         = FQ_AW'(cur_reg.value);
        fa_wd         = '0;
        fb_wd         = '0;

        case (state_reg)
            ST_INIT: begin
                fa_we = 1'b1;
                fb_we = 1'b1;
                fa_wa = init_idx_reg;
                fb_wa = init_idx_reg;
                if (init_idx_reg == FQ_AW'(VALUE_RANGE - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    init_idx_next = init_idx_reg + FQ_AW'(1);
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    state_next = q_item.reject ? ST_OUT : ST_ADD_RD;
                end
            end
            ST_ADD_RD: begin
                hist_we    = 1'b1;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                fa_we = 1'b1;
                fb_we = 1'b1;
                fa_wd = fa_rd_reg + POS_W'(1);
                fb_wd = fb_rd_reg + POS_W'(1);
                if (fa_rd_reg == '0) begin
                    dist_a_next = dist_a_reg + POS_W'(1);
                end
                if (fb_rd_reg == '0) begin
                    dist_b_next = dist_b_reg + POS_W'(1);
                end
                state_next = ST_CHK;
            end
            ST_CHK: begin
                act_a_next = cond_a;
                act_b_next = cond_b;
                if (cond_a || cond_b) begin
                    state_next = ST_HIST;
                end else if (clearing_reg) begin
                    // tables are back to zero: drop the sequence state
                    wp_next       = '0;
                    left_a_next   = '0;
                    left_b_next   = '0;
                    dist_a_next   = '0;
                    dist_b_next   = '0;
                    total_next    = '0;
                    clearing_next = 1'b0;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_HIST: begin
                state_next = ST_FREQ;
            end
            ST_FREQ: begin
                state_next = ST_DEC;
            end
            ST_DEC: begin
                fa_wa = FQ_AW'(ha_reg);
                fb_wa = FQ_AW'(hb_reg);
                fa_wd = fa_rd_reg - POS_W'(1);
                fb_wd = fb_rd_reg - POS_W'(1);
                if (act_a_reg) begin
                    left_a_next = left_a_reg + POS_W'(1);
                    if (fa_rd_reg != '0) begin
                        fa_we = 1'b1;
                        if (fa_rd_reg == POS_W'(1)) begin
                            dist_a_next = dist_a_reg - POS_W'(1);
                        end
                    end
                end
                if (act_b_reg) begin
                    left_b_next = left_b_reg + POS_W'(1);
                    if (fb_rd_reg != '0) begin
                        fb_we = 1'b1;
                        if (fb_rd_reg == POS_W'(1)) begin
                            dist_b_next = dist_b_reg - POS_W'(1);
                        end
                    end
                end
                state_next = ST_CHK;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = cur_reg.last;
                    m_rej_next   = cur_reg.reject;
                    if (cur_reg.reject) begin
                        m_count_next = total_reg;
                    end else begin
                        m_count_next = total_sat;
                        total_next   = total_sat;
                        wp_next      = wp_reg + POS_W'(1);
                    end
                    if (cur_reg.last) begin
                        clearing_next = 1'b1;
                        state_next    = ST_CHK;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wp_reg[HA_W-1:0]] <= cur_reg.value;
        end
        if (state_reg == ST_HIST) begin
            ha_reg <= hist_mem[left_a_reg[HA_W-1:0]];
            hb_reg <= hist_mem[left_b_reg[HA_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (fa_we) begin
            fa_mem[fa_wa] <= fa_wd;
        end
        fa_rd_reg <= fa_mem[fa_ra];
    end

    always_ff @(posedge aclk) begin
        if (fb_we) begin
            fb_mem[fb_wa] <= fb_wd;
        end
        fb_rd_reg <= fb_mem[fb_ra];
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
        m_rej_reg   <= m_rej_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            wp_reg       <= '0;
            left_a_reg   <= '0;
            left_b_reg   <= '0;
            dist_a_reg   <= '0;
            dist_b_reg   <= '0;
            total_reg    <= '0;
            clearing_reg <= 1'b0;
            act_a_reg    <= 1'b0;
            act_b_reg    <= 1'b0;
            init_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            left_a_reg   <= left_a_next;
            left_b_reg   <= left_b_next;
            dist_a_reg   <= dist_a_next;
            dist_b_reg   <= dist_b_next;
            total_reg    <= total_next;
            clearing_reg <= clearing_next;
            act_a_reg    <= act_a_next;
            act_b_reg    <= act_b_next;
            init_idx_reg <= init_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_count_reg);
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_rej_reg;

    always_comb begin
        status.init_busy = (state_reg == ST_INIT);
        status.idle      = (state_reg == ST_IDLE);
    end

endmodule

`default_nettype wire
